// ===== hdl/cpbc_pkg.sv =====
`timescale 1ns / 1ps

package cpbc_pkg;

   // Payload widths
   localparam int ANGLE_W = 16;
   localparam int POS_W   = 16;
   localparam int DT_W    = 16;
   localparam int ACCEL_W = 32;
   localparam int GAIN_W  = 32;
   localparam int LIMIT_W = 15;

   // Register port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_ANGLE_GAIN_P   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANGLE_GAIN_D   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_POS_GAIN_P     = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_POS_GAIN_D     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_POSITION_LIMIT = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_ANGLE_LIMIT    = 3'd5;

   localparam logic [LIMIT_W-1:0] POSITION_LIMIT_RST = 15'd1900;
   localparam logic [LIMIT_W-1:0] ANGLE_LIMIT_RST    = 15'd4500;

   // Datapath widths
   localparam int HALF_W = 32;
   localparam int WORD_W = 64;
   localparam int PROD_W = 96;
   localparam int ERR_W  = 48;
   localparam int Q_BITS = 8;

   // Divider: four quotient bits per cycle over the whole word
   localparam int DIV_BITS  = 4;
   localparam int DIV_STEPS = WORD_W / DIV_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Constant multipliers
   localparam logic [GAIN_W-1:0] US_PER_S   = 32'd1000000;
   localparam logic [GAIN_W-1:0] POS_SCALE  = 32'd25600;
   localparam logic [GAIN_W-1:0] RATE_SCALE = 32'd100;

   // Magnitude ceiling of every scaled product
   localparam logic [WORD_W-1:0] MAG_CAP = 64'h1000_0000_0000_0000;
   localparam logic signed [WORD_W-1:0] MAG_CAP_S = 64'sh1000_0000_0000_0000;

   localparam logic signed [WORD_W-1:0] ERR_MAX = 64'sd140737488355327;
   localparam logic signed [WORD_W-1:0] ERR_MIN = -64'sd140737488355328;
   localparam logic signed [WORD_W-1:0] CMD_MAX = 64'sd2147483647;
   localparam logic signed [WORD_W-1:0] CMD_MIN = -64'sd2147483648;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_MLO,
      ST_MHI,
      ST_MADD,
      ST_MFIN,
      ST_WB,
      ST_DIV,
      ST_DFIN,
      ST_ERR,
      ST_CMD,
      ST_OUT
   } state_type;

   // Operations in the order the sequencer runs them
   typedef enum logic [2:0] {
      OP_POS_SCALE,
      OP_COMP_P,
      OP_DPOS_MUL,
      OP_DPOS_SCALE,
      OP_COMP_D,
      OP_DERR_MUL,
      OP_ACC_P,
      OP_ACC_D
   } op_type;

endpackage

// ===== hdl/cpbc_req_if.sv =====
`timescale 1ns / 1ps

interface cpbc_req_if;
   import cpbc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] angle_centideg;
   logic signed [POS_W-1:0]   cart_position;
   logic [DT_W-1:0]           elapsed_us;
   logic                      stop_switch;

   modport source (
      output valid, angle_centideg, cart_position, elapsed_us, stop_switch,
      input  ready
   );

   modport sink (
      input  valid, angle_centideg, cart_position, elapsed_us, stop_switch,
      output ready
   );

endinterface

// ===== hdl/cpbc_rsp_if.sv =====
`timescale 1ns / 1ps

interface cpbc_rsp_if;
   import cpbc_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [ACCEL_W-1:0] accel_command;
   logic                      cutoff;

   modport source (
      output valid, accel_command, cutoff,
      input  ready
   );

   modport sink (
      input  valid, accel_command, cutoff,
      output ready
   );

endinterface

// ===== hdl/cascaded_pd_balance_controller.sv =====
// Channel   Direction  Contents
// req_ch    in         angle_centideg, cart_position, elapsed_us, stop_switch
// rsp_ch    out        accel_command, cutoff
// csr_*     in         csr_we, csr_addr, csr_wdata (write only)
//
// A request occupies the block until its result moves to the output register; only then
// does it return to idle and take the next request. The pace is set by one shared 32x32
// multiplier (eight products, each through load, low half, high half, add, finish and
// write-back) and one divider that retires four quotient bits a cycle (two divisions).
// Reset is synchronous; it restores the register defaults and clears the stored errors.
// A stalled result is held in the output register; a further request is still accepted
// and waits at the end of its computation until that register is free.
`timescale 1ns / 1ps

module cascaded_pd_balance_controller #(
   parameter int GAIN_FRAC_BITS = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   cpbc_req_if.sink                         req_ch,
   cpbc_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [cpbc_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [cpbc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import cpbc_pkg::*;

   localparam logic [GAIN_W-1:0] ANGLE_GAIN_P_RST = GAIN_W'(64'd10 << GAIN_FRAC_BITS);
   localparam logic [GAIN_W-1:0] ANGLE_GAIN_D_RST = GAIN_W'(64'd1 << GAIN_FRAC_BITS);
   localparam logic [GAIN_W-1:0] POS_GAIN_P_RST   =
      GAIN_W'(((64'd4 << GAIN_FRAC_BITS) + 64'd150) / 64'd300);
   localparam logic [GAIN_W-1:0] POS_GAIN_D_RST   =
      GAIN_W'(((64'd1 << GAIN_FRAC_BITS) + 64'd750) / 64'd1500);

   // Configuration registers
   logic [GAIN_W-1:0]  angle_gain_p_ff;
   logic [GAIN_W-1:0]  angle_gain_d_ff;
   logic [GAIN_W-1:0]  pos_gain_p_ff;
   logic [GAIN_W-1:0]  pos_gain_d_ff;
   logic [LIMIT_W-1:0] position_limit_ff;
   logic [LIMIT_W-1:0] angle_limit_ff;

   // Sequencer
   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   // Latched request
   logic signed [ANGLE_W-1:0] ang_ff, ang_in;
   logic signed [POS_W-1:0]   pos_ff, pos_in;
   logic [DT_W-1:0]           dt_ff, dt_in;
   logic                      stop_ff, stop_in;

   // Stored errors
   logic signed [POS_W-1:0] prev_pos_ff, prev_pos_in;
   logic signed [ERR_W-1:0] prev_err_ff, prev_err_in;

   // Shared multiplier
   logic                     opd_neg_ff, opd_neg_in;
   logic [WORD_W-1:0]        opd_mag_ff, opd_mag_in;
   logic [GAIN_W-1:0]        gain_ff, gain_in;
   logic                     frac_ff, frac_in;
   logic [WORD_W-1:0]        pp_ff, pp_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic signed [WORD_W-1:0] res_ff, res_in;

   // Working values
   logic signed [WORD_W-1:0] tmp_ff, tmp_in;
   logic signed [WORD_W-1:0] sum_ff, sum_in;
   logic signed [ERR_W-1:0]  err_ff, err_in;

   // Shared divider
   logic                 div_neg_ff, div_neg_in;
   logic [WORD_W-1:0]    div_word_ff, div_word_in;
   logic [DT_W-1:0]      rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   // Result before the output register
   logic signed [ACCEL_W-1:0] cmd_ff, cmd_in;
   logic                      cut_ff, cut_in;

   // Output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [ACCEL_W-1:0] rsp_accel_ff, rsp_accel_in;
   logic                      rsp_cut_ff, rsp_cut_in;

   // Combinational helpers
   logic                     req_fire;
   logic                     out_free;
   logic                     div_last;
   logic signed [WORD_W-1:0] pos_diff;
   logic signed [WORD_W-1:0] err_diff;
   logic signed [WORD_W-1:0] opd_val;
   logic [GAIN_W-1:0]        opd_gain;
   logic                     opd_frac;
   logic [HALF_W-1:0]        mul_half;
   logic [WORD_W-1:0]        mul_prod;
   logic [PROD_W-1:0]        prod_shf;
   logic [WORD_W-1:0]        prod_cap;
   logic [DT_W:0]            div_rx;
   logic [DT_W-1:0]          div_rem_nx;
   logic [WORD_W-1:0]        div_word_nx;
   logic signed [WORD_W-1:0] err_sum;
   logic signed [WORD_W-1:0] cmd_q;
   logic signed [POS_W:0]    pos_wide;
   logic signed [POS_W:0]    plim_wide;
   logic signed [ANGLE_W:0]  ang_wide;
   logic [ANGLE_W:0]         ang_mag;
   logic                     cut_now;

   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign div_last     = (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign req_ch.ready = (state_ff == ST_IDLE);

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.accel_command = rsp_accel_ff;
   assign rsp_ch.cutoff        = rsp_cut_ff;

   assign pos_diff = WORD_W'(pos_ff) - WORD_W'(prev_pos_ff);
   assign err_diff = WORD_W'(err_ff) - WORD_W'(prev_err_ff);

   // Configuration writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         angle_gain_p_ff   <= ANGLE_GAIN_P_RST;
         angle_gain_d_ff   <= ANGLE_GAIN_D_RST;
         pos_gain_p_ff     <= POS_GAIN_P_RST;
         pos_gain_d_ff     <= POS_GAIN_D_RST;
         position_limit_ff <= POSITION_LIMIT_RST;
         angle_limit_ff    <= ANGLE_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_ANGLE_GAIN_P:   angle_gain_p_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_ANGLE_GAIN_D:   angle_gain_d_ff   <= csr_wdata[GAIN_W-1:0];
            CSR_POS_GAIN_P:     pos_gain_p_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_POS_GAIN_D:     pos_gain_d_ff     <= csr_wdata[GAIN_W-1:0];
            CSR_POSITION_LIMIT: position_limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_ANGLE_LIMIT:    angle_limit_ff    <= csr_wdata[LIMIT_W-1:0];
            default: ;
         endcase
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      opd_val  = '0;
      opd_gain = '0;
      opd_frac = 1'b0;
      unique case (op_ff)
         OP_POS_SCALE: begin
            opd_val  = WORD_W'(pos_ff);
            opd_gain = POS_SCALE;
         end
         OP_COMP_P: begin
            opd_val  = tmp_ff;
            opd_gain = pos_gain_p_ff;
            opd_frac = 1'b1;
         end
         OP_DPOS_MUL: begin
            opd_val  = pos_diff <<< Q_BITS;
            opd_gain = US_PER_S;
         end
         OP_DPOS_SCALE: begin
            opd_val  = tmp_ff;
            opd_gain = RATE_SCALE;
         end
         OP_COMP_D: begin
            opd_val  = tmp_ff;
            opd_gain = pos_gain_d_ff;
            opd_frac = 1'b1;
         end
         OP_DERR_MUL: begin
            opd_val  = err_diff;
            opd_gain = US_PER_S;
         end
         OP_ACC_P: begin
            opd_val  = WORD_W'(err_ff);
            opd_gain = angle_gain_p_ff;
            opd_frac = 1'b1;
         end
         OP_ACC_D: begin
            opd_val  = tmp_ff;
            opd_gain = angle_gain_d_ff;
            opd_frac = 1'b1;
         end
         default: ;
      endcase
   end

   // The magnitude is multiplied in two halves, low half first.
   always_comb begin
      mul_half = (state_ff == ST_MHI) ? opd_mag_ff[WORD_W-1:HALF_W] : opd_mag_ff[HALF_W-1:0];
      mul_prod = WORD_W'(mul_half) * WORD_W'(gain_ff);
   end

   always_comb begin
      prod_shf = frac_ff ? (prod_ff >> GAIN_FRAC_BITS) : prod_ff;
      prod_cap = (prod_shf > PROD_W'(MAG_CAP)) ? MAG_CAP : prod_shf[WORD_W-1:0];
   end

   // Restoring division, four quotient bits per cycle.
   always_comb begin
      div_rem_nx  = rem_ff;
      div_word_nx = div_word_ff;
      div_rx      = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         div_rx      = {div_rem_nx, div_word_nx[WORD_W-1]};
         div_word_nx = {div_word_nx[WORD_W-2:0], 1'b0};
         if (div_rx >= {1'b0, dt_ff}) begin
            div_rx         = div_rx - {1'b0, dt_ff};
            div_word_nx[0] = 1'b1;
         end
         div_rem_nx = div_rx[DT_W-1:0];
      end
   end

   // Angle error and command saturation, safety cutoff.
   always_comb begin
      err_sum = (WORD_W'(ang_ff) <<< Q_BITS) + sum_ff;
      cmd_q   = sum_ff[WORD_W-1] ? ((sum_ff + WORD_W'(255)) >>> Q_BITS) : (sum_ff >>> Q_BITS);

      pos_wide  = {pos_ff[POS_W-1], pos_ff};
      plim_wide = {2'b00, position_limit_ff};
      ang_wide  = {ang_ff[ANGLE_W-1], ang_ff};
      ang_mag   = ang_wide[ANGLE_W] ? (ANGLE_W+1)'(-ang_wide) : ang_wide;
      cut_now   = stop_ff || (pos_wide > plim_wide) || (pos_wide < -plim_wide) ||
                  (ang_mag > {2'b00, angle_limit_ff});
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_fire) state_in = ST_LOAD;
         ST_LOAD: state_in = ST_MLO;
         ST_MLO:  state_in = ST_MHI;
         ST_MHI:  state_in = ST_MADD;
         ST_MADD: state_in = ST_MFIN;
         ST_MFIN: state_in = ST_WB;
         ST_WB: begin
            unique case (op_ff)
               OP_DPOS_MUL, OP_DERR_MUL: state_in = ST_DIV;
               OP_COMP_D:                state_in = ST_ERR;
               OP_ACC_D:                 state_in = ST_CMD;
               default:                  state_in = ST_LOAD;
            endcase
         end
         ST_DIV:  if (div_last) state_in = ST_DFIN;
         ST_DFIN: state_in = ST_LOAD;
         ST_ERR:  state_in = ST_LOAD;
         ST_CMD:  state_in = ST_OUT;
         ST_OUT:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs
   always_comb begin
      op_in        = op_ff;
      ang_in       = ang_ff;
      pos_in       = pos_ff;
      dt_in        = dt_ff;
      stop_in      = stop_ff;
      prev_pos_in  = prev_pos_ff;
      prev_err_in  = prev_err_ff;
      opd_neg_in   = opd_neg_ff;
      opd_mag_in   = opd_mag_ff;
      gain_in      = gain_ff;
      frac_in      = frac_ff;
      pp_in        = pp_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      tmp_in       = tmp_ff;
      sum_in       = sum_ff;
      err_in       = err_ff;
      div_neg_in   = div_neg_ff;
      div_word_in  = div_word_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      cmd_in       = cmd_ff;
      cut_in       = cut_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_accel_in = rsp_accel_ff;
      rsp_cut_in   = rsp_cut_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               ang_in  = req_ch.angle_centideg;
               pos_in  = req_ch.cart_position;
               // A zero interval is taken as one microsecond.
               dt_in   = (req_ch.elapsed_us == '0) ? DT_W'(1) : req_ch.elapsed_us;
               stop_in = req_ch.stop_switch;
               op_in   = OP_POS_SCALE;
            end
         end
         ST_LOAD: begin
            opd_neg_in = opd_val[WORD_W-1];
            opd_mag_in = opd_val[WORD_W-1] ? (WORD_W'(0) - opd_val) : opd_val;
            gain_in    = opd_gain;
            frac_in    = opd_frac;
         end
         ST_MLO: pp_in = mul_prod;
         ST_MHI: begin
            pp_in   = mul_prod;
            prod_in = PROD_W'(pp_ff);
         end
         ST_MADD: prod_in = prod_ff + {pp_ff, HALF_W'(0)};
         ST_MFIN: res_in = opd_neg_ff ? (WORD_W'(0) - prod_cap) : prod_cap;
         ST_WB: begin
            unique case (op_ff)
               OP_POS_SCALE, OP_DPOS_SCALE: begin
                  tmp_in = res_ff;
                  op_in  = op_type'(op_ff + 3'd1);
               end
               OP_COMP_P, OP_ACC_P: begin
                  sum_in = res_ff;
                  op_in  = op_type'(op_ff + 3'd1);
               end
               OP_COMP_D: begin
                  sum_in = sum_ff + res_ff;
                  op_in  = OP_DERR_MUL;
               end
               OP_ACC_D: sum_in = sum_ff + res_ff;
               OP_DPOS_MUL, OP_DERR_MUL: begin
                  div_neg_in  = res_ff[WORD_W-1];
                  div_word_in = res_ff[WORD_W-1] ? (WORD_W'(0) - res_ff) : res_ff;
                  rem_in      = '0;
                  div_cnt_in  = '0;
               end
               default: ;
            endcase
         end
         ST_DIV: begin
            rem_in      = div_rem_nx;
            div_word_in = div_word_nx;
            div_cnt_in  = div_cnt_ff + DIV_CNT_W'(1);
         end
         ST_DFIN: begin
            tmp_in = div_neg_ff ? (WORD_W'(0) - div_word_ff) : div_word_ff;
            op_in  = op_type'(op_ff + 3'd1);
         end
         ST_ERR: begin
            if (err_sum > ERR_MAX) begin
               err_in = ERR_MAX[ERR_W-1:0];
            end else if (err_sum < ERR_MIN) begin
               err_in = ERR_MIN[ERR_W-1:0];
            end else begin
               err_in = err_sum[ERR_W-1:0];
            end
         end
         ST_CMD: begin
            if (cut_now) begin
               cmd_in = '0;
            end else if (cmd_q > CMD_MAX) begin
               cmd_in = CMD_MAX[ACCEL_W-1:0];
            end else if (cmd_q < CMD_MIN) begin
               cmd_in = CMD_MIN[ACCEL_W-1:0];
            end else begin
               cmd_in = cmd_q[ACCEL_W-1:0];
            end
            cut_in = cut_now;
            // The stored errors advance on every request, cut off or not.
            prev_pos_in = pos_ff;
            prev_err_in = err_ff;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_accel_in = cmd_ff;
               rsp_cut_in   = cut_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_POS_SCALE;
         prev_pos_ff  <= '0;
         prev_err_ff  <= '0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         prev_pos_ff  <= prev_pos_in;
         prev_err_ff  <= prev_err_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ang_ff       <= ang_in;
      pos_ff       <= pos_in;
      dt_ff        <= dt_in;
      stop_ff      <= stop_in;
      opd_neg_ff   <= opd_neg_in;
      opd_mag_ff   <= opd_mag_in;
      gain_ff      <= gain_in;
      frac_ff      <= frac_in;
      pp_ff        <= pp_in;
      prod_ff      <= prod_in;
      res_ff       <= res_in;
      tmp_ff       <= tmp_in;
      sum_ff       <= sum_in;
      err_ff       <= err_in;
      div_neg_ff   <= div_neg_in;
      div_word_ff  <= div_word_in;
      rem_ff       <= rem_in;
      cmd_ff       <= cmd_in;
      cut_ff       <= cut_in;
      rsp_accel_ff <= rsp_accel_in;
      rsp_cut_ff   <= rsp_cut_in;
   end

   a_cutoff_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.cutoff |-> rsp_ch.accel_command == '0)
      else $error("cutoff result carries a non-zero command");

   a_start_seq: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == ST_LOAD && op_ff == OP_POS_SCALE)
      else $error("accepted request did not start the operation sequence");

   a_prod_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_WB |-> res_ff <= MAG_CAP_S && res_ff >= -MAG_CAP_S)
      else $error("scaled product exceeds its magnitude ceiling");

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < dt_ff)
      else $error("divider remainder not below the divisor");

endmodule
